>>> hdl/fmtrs_pkg.sv
// package: command codes, register map, shadow reset values and the microcode table
package fmtrs_pkg;

	// command codes
	localparam logic [3:0] REQ_CLEAR    = 4'd0;
	localparam logic [3:0] REQ_STARTUP  = 4'd1;
	localparam logic [3:0] REQ_ON       = 4'd2;
	localparam logic [3:0] REQ_OFF      = 4'd3;
	localparam logic [3:0] REQ_MUTE     = 4'd4;
	localparam logic [3:0] REQ_UNMUTE   = 4'd5;
	localparam logic [3:0] REQ_INLEVEL  = 4'd6;
	localparam logic [3:0] REQ_OUTPOWER = 4'd7;
	localparam logic [3:0] REQ_TUNE     = 4'd8;
	localparam logic [3:0] REQ_PREEMPH  = 4'd9;
	localparam logic [3:0] REQ_PILOT    = 4'd10;
	localparam logic [3:0] REQ_SUBC     = 4'd11;
	localparam logic [3:0] REQ_PUMPS    = 4'd12;
	localparam logic [3:0] REQ_UNLOCK   = 4'd13;
	localparam logic [3:0] REQ_BAND     = 4'd14;
	localparam logic [3:0] REQ_RESET    = 4'd15;

	// transmitter register addresses
	localparam logic [3:0] ADDR_MODE     = 4'd0;
	localparam logic [3:0] ADDR_PILOT    = 4'd1;
	localparam logic [3:0] ADDR_POWER    = 4'd2;
	localparam logic [3:0] ADDR_DIV_LOW  = 4'd3;
	localparam logic [3:0] ADDR_DIV_HIGH = 4'd4;
	localparam logic [3:0] ADDR_PUMP     = 4'd6;
	localparam logic [3:0] ADDR_BAND     = 4'd8;
	localparam logic [3:0] ADDR_RESET    = 4'd14;

	localparam logic [7:0] CHIP_RESET_DATA = 8'h05;

	// shadow reset values
	localparam logic [7:0] MODE_INIT     = 8'h00;
	localparam logic [7:0] PILOT_INIT    = 8'hB4;
	localparam logic [7:0] POWER_INIT    = 8'h05;
	localparam logic [7:0] DIV_LOW_INIT  = 8'h8A;
	localparam logic [7:0] DIV_HIGH_INIT = 8'h2E;
	localparam logic [7:0] PUMP_INIT     = 8'h1A;
	localparam logic [7:0] BAND_INIT     = 8'h1B;

	// band thresholds and divider constants
	localparam logic [26:0] BAND_EDGE_LOW  = 27'd88500000;
	localparam logic [26:0] BAND_EDGE_MID  = 27'd97900000;
	localparam logic [26:0] BAND_EDGE_HIGH = 27'd103000000;
	localparam logic [27:0] DIV_OFFSET     = 28'd304000;
	localparam int          DIV_SHIFT      = 13;

	// microcode entry points
	localparam int PC_CLEAR    = 0;
	localparam int PC_STARTUP  = 1;
	localparam int PC_ON       = 16;
	localparam int PC_OFF      = 17;
	localparam int PC_MUTE     = 18;
	localparam int PC_UNMUTE   = 19;
	localparam int PC_INLEVEL  = 20;
	localparam int PC_OUTPOWER = 21;
	localparam int PC_PREEMPH  = 22;
	localparam int PC_PILOT    = 23;
	localparam int PC_SUBC     = 24;
	localparam int PC_PUMPS    = 25;
	localparam int PC_UNLOCK   = 26;
	localparam int PC_BAND     = 27;
	localparam int PC_RESET    = 28;
	localparam int PC_TUNE     = 29;
	localparam int UC_DEPTH    = 35;
	localparam int PC_W        = $clog2(UC_DEPTH);

	typedef logic [PC_W-1:0] pc_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} state_t;

	// shadow update performed by one step
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_POWER,
		OP_MUTE,
		OP_INLEVEL,
		OP_OUTPWR,
		OP_PREEMPH,
		OP_PILOT,
		OP_SUBC,
		OP_PUMPS,
		OP_UNLOCK,
		OP_BAND,
		OP_BANDTUNE
	} op_t;

	// where the step argument comes from
	typedef enum logic [1:0] {
		SRC_IMM,
		SRC_SET,
		SRC_FLAG
	} src_t;

	// one control word
	typedef struct packed {
		op_t        op;
		src_t       src;
		logic [1:0] imm;
		logic       load_div;
		logic       emit;
		logic [3:0] addr;
		logic       fin;
		logic       fin_nf;
	} ucode_t;

	function automatic ucode_t mk(op_t op, src_t src, logic [1:0] imm, logic load_div,
		logic emit, logic [3:0] addr, logic fin, logic fin_nf);
		ucode_t u;
		u.op       = op;
		u.src      = src;
		u.imm      = imm;
		u.load_div = load_div;
		u.emit     = emit;
		u.addr     = addr;
		u.fin      = fin;
		u.fin_nf   = fin_nf;
		return u;
	endfunction

	// microcode program
	function automatic ucode_t ucode_rom(pc_t pc);
		ucode_t u;
		case (int'(pc))
			PC_CLEAR:        u = mk(OP_CLEAR, SRC_IMM, 2'd0, 1'b0, 1'b0, ADDR_MODE, 1'b1, 1'b0);
			// startup sequence
			PC_STARTUP:      u = mk(OP_CLEAR, SRC_IMM, 2'd0, 1'b0, 1'b1, ADDR_RESET, 1'b0, 1'b0);
			PC_STARTUP + 1:  u = mk(OP_PILOT, SRC_IMM, 2'd1, 1'b0, 1'b1, ADDR_PILOT, 1'b0, 1'b0);
			PC_STARTUP + 2:  u = mk(OP_OUTPWR, SRC_IMM, 2'd1, 1'b0, 1'b1, ADDR_POWER, 1'b0, 1'b0);
			PC_STARTUP + 3:  u = mk(OP_UNLOCK, SRC_IMM, 2'd1, 1'b0, 1'b1, ADDR_POWER, 1'b0, 1'b0);
			PC_STARTUP + 4:  u = mk(OP_SUBC, SRC_IMM, 2'd0, 1'b0, 1'b1, ADDR_PILOT, 1'b0, 1'b0);
			PC_STARTUP + 5:  u = mk(OP_BANDTUNE, SRC_IMM, 2'd0, 1'b0, 1'b1, ADDR_BAND, 1'b0, 1'b0);
			PC_STARTUP + 6:  u = mk(OP_PUMPS, SRC_IMM, 2'd1, 1'b1, 1'b1, ADDR_PUMP, 1'b0, 1'b0);
			PC_STARTUP + 7:  u = mk(OP_NONE, SRC_IMM, 2'd0, 1'b0, 1'b1, ADDR_DIV_LOW, 1'b0, 1'b0);
			PC_STARTUP + 8:  u = mk(OP_NONE, SRC_IMM, 2'd0, 1'b0, 1'b1, ADDR_DIV_HIGH, 1'b0, 1'b0);
			PC_STARTUP + 9:  u = mk(OP_PUMPS, SRC_IMM, 2'd0, 1'b0, 1'b1, ADDR_PUMP, 1'b0, 1'b0);
			PC_STARTUP + 10: u = mk(OP_POWER, SRC_IMM, 2'd1, 1'b0, 1'b1, ADDR_MODE, 1'b0, 1'b0);
			PC_STARTUP + 11: u = mk(OP_MUTE, SRC_IMM, 2'd0, 1'b0, 1'b1, ADDR_MODE, 1'b0, 1'b0);
			PC_STARTUP + 12: u = mk(OP_PREEMPH, SRC_IMM, 2'd1, 1'b0, 1'b1, ADDR_MODE, 1'b0, 1'b0);
			PC_STARTUP + 13: u = mk(OP_INLEVEL, SRC_IMM, 2'd1, 1'b0, 1'b1, ADDR_MODE, 1'b0, 1'b0);
			PC_STARTUP + 14: u = mk(OP_NONE, SRC_IMM, 2'd0, 1'b0, 1'b1, ADDR_RESET, 1'b1, 1'b0);
			// single-frame commands
			PC_ON:       u = mk(OP_POWER, SRC_IMM, 2'd1, 1'b0, 1'b1, ADDR_MODE, 1'b1, 1'b0);
			PC_OFF:      u = mk(OP_POWER, SRC_IMM, 2'd0, 1'b0, 1'b1, ADDR_MODE, 1'b1, 1'b0);
			PC_MUTE:     u = mk(OP_MUTE, SRC_IMM, 2'd1, 1'b0, 1'b1, ADDR_MODE, 1'b1, 1'b0);
			PC_UNMUTE:   u = mk(OP_MUTE, SRC_IMM, 2'd0, 1'b0, 1'b1, ADDR_MODE, 1'b1, 1'b0);
			PC_INLEVEL:  u = mk(OP_INLEVEL, SRC_SET, 2'd0, 1'b0, 1'b1, ADDR_MODE, 1'b1, 1'b0);
			PC_OUTPOWER: u = mk(OP_OUTPWR, SRC_SET, 2'd0, 1'b0, 1'b1, ADDR_POWER, 1'b1, 1'b0);
			PC_PREEMPH:  u = mk(OP_PREEMPH, SRC_SET, 2'd0, 1'b0, 1'b1, ADDR_MODE, 1'b1, 1'b0);
			PC_PILOT:    u = mk(OP_PILOT, SRC_FLAG, 2'd0, 1'b0, 1'b1, ADDR_PILOT, 1'b1, 1'b0);
			PC_SUBC:     u = mk(OP_SUBC, SRC_FLAG, 2'd0, 1'b0, 1'b1, ADDR_PILOT, 1'b1, 1'b0);
			PC_PUMPS:    u = mk(OP_PUMPS, SRC_SET, 2'd0, 1'b0, 1'b1, ADDR_PUMP, 1'b1, 1'b0);
			PC_UNLOCK:   u = mk(OP_UNLOCK, SRC_FLAG, 2'd0, 1'b0, 1'b1, ADDR_POWER, 1'b1, 1'b0);
			PC_BAND:     u = mk(OP_BAND, SRC_SET, 2'd0, 1'b0, 1'b1, ADDR_BAND, 1'b1, 1'b0);
			PC_RESET:    u = mk(OP_NONE, SRC_IMM, 2'd0, 1'b0, 1'b1, ADDR_RESET, 1'b1, 1'b0);
			// tune, with the chip reset frame only when the flag is set
			PC_TUNE:     u = mk(OP_BANDTUNE, SRC_IMM, 2'd0, 1'b0, 1'b1, ADDR_BAND, 1'b0, 1'b0);
			PC_TUNE + 1: u = mk(OP_PUMPS, SRC_IMM, 2'd1, 1'b1, 1'b1, ADDR_PUMP, 1'b0, 1'b0);
			PC_TUNE + 2: u = mk(OP_NONE, SRC_IMM, 2'd0, 1'b0, 1'b1, ADDR_DIV_LOW, 1'b0, 1'b0);
			PC_TUNE + 3: u = mk(OP_NONE, SRC_IMM, 2'd0, 1'b0, 1'b1, ADDR_DIV_HIGH, 1'b0, 1'b0);
			PC_TUNE + 4: u = mk(OP_PUMPS, SRC_IMM, 2'd0, 1'b0, 1'b1, ADDR_PUMP, 1'b0, 1'b1);
			PC_TUNE + 5: u = mk(OP_NONE, SRC_IMM, 2'd0, 1'b0, 1'b1, ADDR_RESET, 1'b1, 1'b0);
			default:     u = mk(OP_NONE, SRC_IMM, 2'd0, 1'b0, 1'b0, ADDR_MODE, 1'b1, 1'b0);
		endcase
		return u;
	endfunction

	// command code to first program step
	function automatic pc_t entry_pc(logic [3:0] req);
		int e;
		case (req)
			REQ_CLEAR:    e = PC_CLEAR;
			REQ_STARTUP:  e = PC_STARTUP;
			REQ_ON:       e = PC_ON;
			REQ_OFF:      e = PC_OFF;
			REQ_MUTE:     e = PC_MUTE;
			REQ_UNMUTE:   e = PC_UNMUTE;
			REQ_INLEVEL:  e = PC_INLEVEL;
			REQ_OUTPOWER: e = PC_OUTPOWER;
			REQ_TUNE:     e = PC_TUNE;
			REQ_PREEMPH:  e = PC_PREEMPH;
			REQ_PILOT:    e = PC_PILOT;
			REQ_SUBC:     e = PC_SUBC;
			REQ_PUMPS:    e = PC_PUMPS;
			REQ_UNLOCK:   e = PC_UNLOCK;
			REQ_BAND:     e = PC_BAND;
			REQ_RESET:    e = PC_RESET;
			default:      e = PC_RESET;
		endcase
		return pc_t'(e);
	endfunction

endpackage

>>> hdl/fmtrs_if.sv
// interfaces: command channel and frame channel
interface fmtrs_cmd_if;
	logic        valid;
	logic        ready;
	logic [3:0]  req_type;
	logic [26:0] frequency_hz;
	logic [1:0]  setting;
	logic        flag;

	modport source (output valid, output req_type, output frequency_hz, output setting,
		output flag, input ready);
	modport sink (input valid, input req_type, input frequency_hz, input setting,
		input flag, output ready);
endinterface

interface fmtrs_frame_if;
	logic       valid;
	logic       ready;
	logic [3:0] reg_addr;
	logic [7:0] reg_data;
	logic       last_frame;

	modport source (output valid, output reg_addr, output reg_data, output last_frame,
		input ready);
	modport sink (input valid, input reg_addr, input reg_data, input last_frame,
		output ready);
endinterface

>>> hdl/fmtrs_datapath.sv
// datapath: shadow registers, field updates, band pick, divider and frame data
module fmtrs_datapath
	import fmtrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  ucode_t      uc,
	input  logic [1:0]  setting,
	input  logic        flag,
	input  logic [26:0] freq,
	output logic [7:0]  frame_data
);

	logic [7:0] mode_q, pilot_q, power_q, div_low_q, div_high_q, pump_q, band_q;
	logic [7:0] mode_d, pilot_d, power_d, div_low_d, div_high_d, pump_d, band_d;
	logic [1:0] arg;
	logic [1:0] tune_band;
	logic [27:0] div_sum;

	// step argument
	always_comb begin
		case (uc.src)
			SRC_SET:  arg = setting;
			SRC_FLAG: arg = {1'b0, flag};
			default:  arg = uc.imm;
		endcase
	end

	// band from the carrier frequency and the divider sum
	always_comb begin
		if (freq < BAND_EDGE_LOW) begin
			tune_band = 2'd3;
		end else if (freq < BAND_EDGE_MID) begin
			tune_band = 2'd2;
		end else if (freq < BAND_EDGE_HIGH) begin
			tune_band = 2'd1;
		end else begin
			tune_band = 2'd0;
		end
		div_sum = {1'b0, freq} + DIV_OFFSET;
	end

	// masked field update for this step
	always_comb begin
		mode_d     = mode_q;
		pilot_d    = pilot_q;
		power_d    = power_q;
		div_low_d  = div_low_q;
		div_high_d = div_high_q;
		pump_d     = pump_q;
		band_d     = band_q;
		case (uc.op)
			OP_CLEAR: begin
				mode_d     = MODE_INIT;
				pilot_d    = PILOT_INIT;
				power_d    = POWER_INIT;
				div_low_d  = DIV_LOW_INIT;
				div_high_d = DIV_HIGH_INIT;
				pump_d     = PUMP_INIT;
				band_d     = BAND_INIT;
			end
			OP_POWER:   mode_d[1:0] = arg[0] ? 2'b01 : 2'b10;
			OP_MUTE:    mode_d[2] = arg[0];
			OP_INLEVEL: begin
				if (arg != 2'd3) mode_d[7:6] = arg;
			end
			OP_OUTPWR: begin
				if (arg != 2'd3) power_d[1:0] = arg + 2'd1;
			end
			OP_PREEMPH: begin
				case (arg)
					2'd0:    mode_d[4] = 1'b1;
					2'd1:    mode_d[5:4] = 2'b00;
					2'd2:    mode_d[5:4] = 2'b10;
					default: mode_d = mode_q;
				endcase
			end
			OP_PILOT:  pilot_d[3] = ~arg[0];
			OP_SUBC:   pilot_d[6] = ~arg[0];
			OP_PUMPS: begin
				case (arg)
					2'd0:    pump_d[4:1] = 4'b1101;
					2'd1:    pump_d[4:1] = 4'b1111;
					default: pump_d = pump_q;
				endcase
			end
			OP_UNLOCK:   power_d[2] = arg[0];
			OP_BAND:     band_d[1:0] = arg;
			OP_BANDTUNE: band_d[1:0] = tune_band;
			default:     mode_d = mode_q;
		endcase
		if (uc.load_div) begin
			div_low_d  = div_sum[DIV_SHIFT +: 8];
			div_high_d = 8'(div_sum >> (DIV_SHIFT + 8));
		end
	end

	// frame byte from the updated shadow
	always_comb begin
		case (uc.addr)
			ADDR_MODE:     frame_data = mode_d;
			ADDR_PILOT:    frame_data = pilot_d;
			ADDR_POWER:    frame_data = power_d;
			ADDR_DIV_LOW:  frame_data = div_low_d;
			ADDR_DIV_HIGH: frame_data = div_high_d;
			ADDR_PUMP:     frame_data = pump_d;
			ADDR_BAND:     frame_data = band_d;
			default:       frame_data = CHIP_RESET_DATA;
		endcase
	end

	// shadow registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_INIT;
			pilot_q    <= PILOT_INIT;
			power_q    <= POWER_INIT;
			div_low_q  <= DIV_LOW_INIT;
			div_high_q <= DIV_HIGH_INIT;
			pump_q     <= PUMP_INIT;
			band_q     <= BAND_INIT;
		end else if (step_en) begin
			mode_q     <= mode_d;
			pilot_q    <= pilot_d;
			power_q    <= power_d;
			div_low_q  <= div_low_d;
			div_high_q <= div_high_d;
			pump_q     <= pump_d;
			band_q     <= band_d;
		end
	end

endmodule

>>> hdl/fm_transmitter_register_sequencer.sv
// top level: command sequencer with microcode table, shadow datapath and frame output register
//
//  channel  role  payload                                      handshake
//  cmd      sink  req_type, frequency_hz, setting, flag        valid/ready
//  frame    src   reg_addr, reg_data, last_frame               valid/ready
//
// a command is taken in ST_IDLE, then ST_RUN runs one microcode step per frame, so startup
// sends 15 frames, tune 5 or 6, the others one (clear emits no frame)
// the step counter walks the microcode table one control word per cycle when no step waits
// a step waits while the frame output register is full and not being taken
// reset puts all shadows at their power-up values; no clearing pass is needed
// the next command is taken once the last frame is loaded, even if it still waits
module fm_transmitter_register_sequencer
	import fmtrs_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	fmtrs_cmd_if.sink      cmd,
	fmtrs_frame_if.source  frame
);

	state_t      state_q, state_d;
	pc_t         pc_q, pc_d;
	ucode_t      uc;
	logic        step;
	logic        fin;
	logic        out_free;
	logic [26:0] freq_q;
	logic [1:0]  setting_q;
	logic        flag_q;
	logic [7:0]  frame_data;
	logic        frame_valid_q;
	logic [3:0]  addr_q;
	logic [7:0]  data_q;
	logic        last_q;

	assign uc       = ucode_rom(pc_q);
	assign out_free = !frame_valid_q || frame.ready;

	// sequencer next state
	always_comb begin
		state_d   = state_q;
		pc_d      = pc_q;
		step      = 1'b0;
		fin       = 1'b0;
		cmd.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = ST_RUN;
					pc_d    = entry_pc(cmd.req_type);
				end
			end
			ST_RUN: begin
				if (out_free) begin
					step = 1'b1;
					fin  = uc.fin || (uc.fin_nf && !flag_q);
					if (fin) begin
						state_d = ST_IDLE;
					end else begin
						pc_d = pc_q + pc_t'(1);
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

	// command arguments held for the program
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			freq_q    <= cmd.frequency_hz;
			setting_q <= cmd.setting;
			flag_q    <= cmd.flag;
		end
	end

	fmtrs_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (step),
		.uc         (uc),
		.setting    (setting_q),
		.flag       (flag_q),
		.freq       (freq_q),
		.frame_data (frame_data)
	);

	// frame output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
		end else if (step && uc.emit) begin
			frame_valid_q <= 1'b1;
		end else if (frame.ready) begin
			frame_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && uc.emit) begin
			addr_q <= uc.addr;
			data_q <= frame_data;
			last_q <= fin;
		end
	end

	assign frame.valid      = frame_valid_q;
	assign frame.reg_addr   = addr_q;
	assign frame.reg_data   = data_q;
	assign frame.last_frame = last_q;

endmodule

>>> hdl/fmtrs_checker.sv
// checker on the top level ports, attached by bind
module fmtrs_checker
	import fmtrs_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic       frame_valid,
	input logic       frame_ready,
	input logic [3:0] reg_addr,
	input logic [7:0] reg_data,
	input logic       last_frame
);

	// a stalled frame transaction holds its payload
	a_frame_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_ready |=> frame_valid && $stable(reg_addr)
			&& $stable(reg_data) && $stable(last_frame))
		else $error("frame payload changed while stalled");

	// a command is being worked on right after it is taken
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while previous command in progress");

	// only mapped register addresses go out
	a_addr_map: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> reg_addr == ADDR_MODE || reg_addr == ADDR_PILOT
			|| reg_addr == ADDR_POWER || reg_addr == ADDR_DIV_LOW
			|| reg_addr == ADDR_DIV_HIGH || reg_addr == ADDR_PUMP
			|| reg_addr == ADDR_BAND || reg_addr == ADDR_RESET)
		else $error("frame to unmapped register address");

	// the chip reset frame carries its fixed byte
	a_reset_data: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && reg_addr == ADDR_RESET |-> reg_data == CHIP_RESET_DATA)
		else $error("chip reset frame with wrong data");

endmodule

bind fm_transmitter_register_sequencer fmtrs_checker u_fmtrs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.frame_valid (frame.valid),
	.frame_ready (frame.ready),
	.reg_addr    (frame.reg_addr),
	.reg_data    (frame.reg_data),
	.last_frame  (frame.last_frame)
);
